>>> sv/bdq_pkg.sv
// Shared types, codes and defaults of the bounded deque with remove.
package bdq_pkg;

  // Default sizes of the store.
  localparam int unsigned CapacityDef  = 256;
  localparam int unsigned DataWidthDef = 32;

  // Fixed widths of the item and result fields.
  localparam int unsigned FuncW  = 3;
  localparam int unsigned ValueW = 32;
  localparam int unsigned IndexW = 8;
  localparam int unsigned StatW  = 2;

  // Value returned by a read past the count.
  localparam logic signed [ValueW-1:0] ReadMiss = -32'sd1;

  typedef enum logic [FuncW-1:0] {
    FN_PUSH_BACK  = 3'd0,
    FN_PUSH_FRONT = 3'd1,
    FN_POP_BACK   = 3'd2,
    FN_POP_FRONT  = 3'd3,
    FN_READ       = 3'd4,
    FN_REMOVE     = 3'd5,
    FN_CLEAR      = 3'd6
  } func_e;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_OUT_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_REMOVE
  } state_e;

endpackage

>>> sv/bounded_deque_with_remove.sv
// Top level of the bounded double-ended queue with remove-by-value.
//
// Usage: an item (func_i, value_i, index_i) is taken at a rising edge where
// start is high and busy is low. Every item gives exactly one result beat on
// read_value_o, count_o and status_o, marked by done_o for a single cycle.
// The receiver cannot hold a beat off, so there is no stall on that side.
//
// Push, pop, clear and a read past the count give their beat in the cycle
// after the item is taken, and busy stays low, so a new item may follow every
// cycle. A read in range waits for the synchronous entry memory: its data is
// registered in the memory, then in the result registers; busy is high
// meanwhile. A remove walks the live entries through the memory, one read and
// at most one compacting write per cycle, and gives its beat once the walk is
// done, with busy high meanwhile; an empty store answers in the next cycle.
//
// Reset clears the count and the front position, so the store starts empty.
// The entry memory itself is not cleared; only written entries are read.
module bounded_deque_with_remove #(
  parameter int unsigned CAPACITY   = bdq_pkg::CapacityDef,
  parameter int unsigned DATA_WIDTH = bdq_pkg::DataWidthDef,
  localparam int unsigned CntW      = $clog2(CAPACITY + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [bdq_pkg::FuncW-1:0]            func_i,
  input  logic signed [bdq_pkg::ValueW-1:0]    value_i,
  input  logic [bdq_pkg::IndexW-1:0]           index_i,
  output logic                                 done_o,
  output logic signed [bdq_pkg::ValueW-1:0]    read_value_o,
  output logic [CntW-1:0]                      count_o,
  output logic [bdq_pkg::StatW-1:0]            status_o
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned IxW  = (CntW > bdq_pkg::IndexW) ? CntW : bdq_pkg::IndexW;
  localparam logic [AW:0] CapL = (AW + 1)'(CAPACITY);
  localparam logic [AW-1:0] LastSlot = AW'(CAPACITY - 1);

  // Ring position of the entry at a given offset from the front.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] front,
                                          input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, front} + {1'b0, off};
    if (sum >= CapL) begin
      sum = sum - CapL;
    end
    return sum[AW-1:0];
  endfunction

  bdq_pkg::state_e state_q, state_d;
  logic [AW-1:0]   front_q, front_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rd_idx_q, rd_idx_d;
  logic [CntW-1:0] kept_q, kept_d;
  logic            rd_vld_q, rd_vld_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;

  logic                                done_q, done_d;
  logic signed [bdq_pkg::ValueW-1:0]   rv_q, rv_d;
  logic [CntW-1:0]                     res_cnt_q, res_cnt_d;
  bdq_pkg::status_e                    status_q, status_d;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  logic                  accept;
  logic                  is_full, is_empty;
  logic [IxW-1:0]        idx_ext;
  logic                  idx_in_range;
  logic [DATA_WIDTH-1:0] val_st;

  assign accept       = start && !busy;
  assign busy         = (state_q != bdq_pkg::S_IDLE);
  assign is_full      = (count_q == CntW'(CAPACITY));
  assign is_empty     = (count_q == '0);
  assign idx_ext      = IxW'(index_i);
  assign idx_in_range = (idx_ext < IxW'(count_q));
  // Items are stored sign-extended or cut to the entry width.
  assign val_st       = DATA_WIDTH'(value_i);

  bdq_ram #(
    .Width (DATA_WIDTH),
    .Depth (CAPACITY)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    front_d   = front_q;
    count_d   = count_q;
    rd_idx_d  = rd_idx_q;
    rd_vld_d  = 1'b0;
    kept_d    = kept_q;
    val_d     = val_q;
    done_d    = 1'b0;
    rv_d      = rv_q;
    res_cnt_d = res_cnt_q;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_waddr = front_q;
    ram_wdata = val_st;
    ram_raddr = slot(front_q, rd_idx_q[AW-1:0]);

    case (state_q)
      bdq_pkg::S_IDLE: begin
        if (accept) begin
          done_d   = 1'b1;
          rv_d     = '0;
          status_d = bdq_pkg::ST_OK;
          case (bdq_pkg::func_e'(func_i))
            bdq_pkg::FN_PUSH_BACK: begin
              if (is_full) begin
                status_d = bdq_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = slot(front_q, count_q[AW-1:0]);
                count_d   = count_q + CntW'(1);
              end
            end
            bdq_pkg::FN_PUSH_FRONT: begin
              if (is_full) begin
                status_d = bdq_pkg::ST_FULL;
              end else begin
                front_d   = (front_q == '0) ? LastSlot : front_q - AW'(1);
                ram_we    = 1'b1;
                ram_waddr = front_d;
                count_d   = count_q + CntW'(1);
              end
            end
            bdq_pkg::FN_POP_BACK: begin
              if (is_empty) begin
                status_d = bdq_pkg::ST_EMPTY;
              end else begin
                count_d = count_q - CntW'(1);
              end
            end
            bdq_pkg::FN_POP_FRONT: begin
              if (is_empty) begin
                status_d = bdq_pkg::ST_EMPTY;
              end else begin
                front_d = slot(front_q, AW'(1));
                count_d = count_q - CntW'(1);
              end
            end
            bdq_pkg::FN_READ: begin
              if (idx_in_range) begin
                // Result comes out of the memory in the next cycle.
                done_d    = 1'b0;
                ram_raddr = slot(front_q, AW'(idx_ext));
                state_d   = bdq_pkg::S_READ;
              end else begin
                rv_d     = bdq_pkg::ReadMiss;
                status_d = bdq_pkg::ST_OUT_RANGE;
              end
            end
            bdq_pkg::FN_REMOVE: begin
              if (!is_empty) begin
                done_d    = 1'b0;
                ram_raddr = front_q;
                rd_idx_d  = CntW'(1);
                rd_vld_d  = 1'b1;
                kept_d    = '0;
                val_d     = val_st;
                state_d   = bdq_pkg::S_REMOVE;
              end
            end
            bdq_pkg::FN_CLEAR: begin
              front_d = '0;
              count_d = '0;
            end
            default: begin
            end
          endcase
          res_cnt_d = count_d;
        end
      end
      bdq_pkg::S_READ: begin
        done_d    = 1'b1;
        rv_d      = bdq_pkg::ValueW'($signed(ram_rdata));
        status_d  = bdq_pkg::ST_OK;
        res_cnt_d = count_q;
        state_d   = bdq_pkg::S_IDLE;
      end
      bdq_pkg::S_REMOVE: begin
        if (rd_vld_q) begin
          // Keep the entry read last cycle unless it matches.
          if (ram_rdata != val_q) begin
            ram_we    = 1'b1;
            ram_waddr = slot(front_q, kept_q[AW-1:0]);
            ram_wdata = ram_rdata;
            kept_d    = kept_q + CntW'(1);
          end
          if (rd_idx_q < count_q) begin
            ram_raddr = slot(front_q, rd_idx_q[AW-1:0]);
            rd_idx_d  = rd_idx_q + CntW'(1);
            rd_vld_d  = 1'b1;
          end
        end else begin
          count_d   = kept_q;
          done_d    = 1'b1;
          rv_d      = '0;
          status_d  = bdq_pkg::ST_OK;
          res_cnt_d = kept_q;
          state_d   = bdq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bdq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bdq_pkg::S_IDLE;
      front_q  <= '0;
      count_q  <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      front_q  <= front_d;
      count_q  <= count_d;
      rd_vld_q <= rd_vld_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_idx_d;
    kept_q    <= kept_d;
    val_q     <= val_d;
    rv_q      <= rv_d;
    res_cnt_q <= res_cnt_d;
    status_q  <= status_d;
  end

  assign done_o       = done_q;
  assign read_value_o = rv_q;
  assign count_o      = res_cnt_q;
  assign status_o     = status_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_front_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, front_q} < CapL)
    else $error("front position outside the ring");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while an item is still at work");

  a_kept_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bdq_pkg::S_REMOVE) |-> (kept_q <= rd_idx_q))
    else $error("compaction write ran ahead of the read walk");

  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (func_i == bdq_pkg::FN_READ) && idx_in_range)
      |=> busy ##1 done_o)
    else $error("in-range read did not finish two cycles later");
`endif

endmodule

>>> sv/bdq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bdq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
